@@ rtl/core/lbfd_pkg.sv @@
// lbfd_pkg: shared constants and types of the light beacon frequency detector
// no dependencies
package lbfd_pkg;
    localparam int unsigned DivWidth = 18;
    localparam logic [17:0] FreqNumer = 18'd200000;
    localparam logic [31:0] MinGap = 32'd47;
    localparam logic [15:0] TickLimit = 16'd400;
    localparam logic signed [15:0] PeakMax = 16'sd1023;
    localparam logic [15:0] HighReset = 16'd100;
    localparam logic [15:0] LowReset = 16'd50;
    localparam logic [0:0] RegHigh = 1'b0;
    localparam logic [0:0] RegLow = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_AVG  = 5'b00010,
        ST_EDGE = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic [15:0] baseline_out;
        logic signed [15:0] signal_out;
        logic [12:0] frequency;
        logic signed [15:0] peak;
    } result_t;
endpackage

@@ rtl/core/lbfd_stream_if.sv @@
// lbfd_stream_if: valid/ready channel carrying a payload word
// no dependencies
interface lbfd_stream_if #(parameter int unsigned W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/lbfd_divider.sv @@
// lbfd_divider: radix-2 restoring divider of the constant 200000 by the edge gap
// depends on lbfd_pkg
module lbfd_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [12:0] quotient
);
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [17:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [17:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        trial = {rem_reg[31:0], num_reg[17]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'(lbfd_pkg::DivWidth);
            num_next = lbfd_pkg::FreqNumer;
            rem_next = '0;
            quo_next = '0;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            num_next = {num_reg[16:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[16:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[16:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign quotient = quo_next[12:0];
endmodule

@@ rtl/core/light_beacon_frequency_detector_core.sv @@
// light_beacon_frequency_detector_core: top level of the beacon detector
// depends on lbfd_pkg, lbfd_stream_if, lbfd_divider
// An item passes ST_AVG, ST_EDGE and, with an accepted rising edge, ST_DIV,
// where the bit-serial divider computes 200000/gap one quotient bit a cycle; then the
// word sits in the output register, and the next item is taken once it leaves.
// Input word is {now_ms, sample, chan}; output word is {peak, frequency,
// signal_out, baseline_out} from high bits down.
module light_beacon_frequency_detector_core #(
    parameter int unsigned CHANNELS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    lbfd_stream_if.sink   in_s,
    lbfd_stream_if.source out_s,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    lbfd_pkg::state_t state_reg, state_next;
    logic [15:0] avg_reg [CHANNELS];
    logic [31:0] etime_reg [CHANNELS];
    logic [12:0] freq_reg [CHANNELS];
    logic [15:0] ticks_reg [CHANNELS];
    logic [CHANNELS-1:0] high_reg;
    logic signed [15:0] peak_reg [CHANNELS];
    logic signed [15:0] hth_reg, lth_reg;
    logic [CW-1:0] ch_reg;
    logic [9:0] x_reg;
    logic [31:0] now_reg;
    logic [22:0] prod_reg;
    logic [15:0] b_reg;
    logic signed [15:0] sig_reg;
    logic [31:0] dt_reg;
    logic ovalid_reg;
    lbfd_pkg::result_t res_reg;
    logic [CW-1:0] ch_in;
    logic [22:0] acc;
    logic [15:0] q0, bnew;
    logic div_start, div_done;
    logic [12:0] div_q;
    logic rise;

    lbfd_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(dt_reg),
        .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        if (CHANNELS == 1 || 32'(in_s.data[0]) >= CHANNELS)
            ch_in = CW'(CHANNELS - 1);
        else
            ch_in = CW'(in_s.data[0]);
    end

    // divide by 100 via reciprocal: q = (v*10737419)>>30, exact below 2^23
    logic [46:0] recip;
    always_comb
    begin
        acc = prod_reg;
        recip = 47'(acc) * 47'd10737419;
        q0 = recip[45:30];
        bnew = ({6'd0, x_reg} > q0) ? q0 + 16'd1 : q0 - 16'd1;
    end

    assign rise = !high_reg[ch_reg] && (sig_reg > hth_reg);
    assign in_s.ready = (state_reg == lbfd_pkg::ST_IDLE) && !ovalid_reg;
    assign div_start = (state_reg == lbfd_pkg::ST_EDGE) && rise
        && (now_reg - etime_reg[ch_reg] > lbfd_pkg::MinGap);
    assign out_s.valid = ovalid_reg;
    assign out_s.data = {res_reg.peak, res_reg.frequency, res_reg.signal_out,
        res_reg.baseline_out};

    logic [12:0] f_new;
    logic [15:0] t_new;
    logic signed [15:0] p_new;
    logic acc_edge, finish;
    always_comb
    begin
        acc_edge = (state_reg == lbfd_pkg::ST_DIV);
        finish = ((state_reg == lbfd_pkg::ST_EDGE) && !div_start) || div_done;
        f_new = acc_edge ? div_q : freq_reg[ch_reg];
        t_new = acc_edge ? 16'd1 : ticks_reg[ch_reg] + 16'd1;
        if (t_new > lbfd_pkg::TickLimit && !acc_edge)
            f_new = '0;
        p_new = peak_reg[ch_reg];
        if (rise)
            p_new = sig_reg;
        else if (high_reg[ch_reg] && p_new < sig_reg)
            p_new = sig_reg;
        if (f_new == '0 || p_new > lbfd_pkg::PeakMax)
            p_new = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbfd_pkg::ST_IDLE: if (in_s.valid && in_s.ready) state_next = lbfd_pkg::ST_AVG;
            lbfd_pkg::ST_AVG:  state_next = lbfd_pkg::ST_EDGE;
            lbfd_pkg::ST_EDGE: state_next = div_start ? lbfd_pkg::ST_DIV : lbfd_pkg::ST_IDLE;
            lbfd_pkg::ST_DIV:  if (div_done) state_next = lbfd_pkg::ST_IDLE;
            lbfd_pkg::ST_OUT:  state_next = lbfd_pkg::ST_IDLE;
            default:           state_next = lbfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbfd_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
            hth_reg <= signed'(lbfd_pkg::HighReset);
            lth_reg <= signed'(lbfd_pkg::LowReset);
            high_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                avg_reg[i] <= '0;
                etime_reg[i] <= '0;
                freq_reg[i] <= '0;
                ticks_reg[i] <= '0;
                peak_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == lbfd_pkg::RegHigh) hth_reg <= signed'(cfg_data);
                else lth_reg <= signed'(cfg_data);
            end
            if (out_s.valid && out_s.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == lbfd_pkg::ST_AVG)
                avg_reg[ch_reg] <= bnew;
            if ((state_reg == lbfd_pkg::ST_EDGE || acc_edge) && finish)
            begin
                ovalid_reg <= 1'b1;
                freq_reg[ch_reg] <= f_new;
                ticks_reg[ch_reg] <= t_new;
                peak_reg[ch_reg] <= p_new;
                if (rise)
                begin
                    high_reg[ch_reg] <= 1'b1;
                    etime_reg[ch_reg] <= now_reg;
                end
                else if (high_reg[ch_reg] && sig_reg < lth_reg)
                    high_reg[ch_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_s.valid && in_s.ready)
        begin
            ch_reg <= ch_in;
            x_reg <= in_s.data[10:1];
            now_reg <= in_s.data[42:11];
            prod_reg <= 23'(avg_reg[ch_in]) * 23'd99 + 23'(in_s.data[10:1]);
        end
        if (state_reg == lbfd_pkg::ST_AVG)
        begin
            b_reg <= bnew;
            sig_reg <= signed'(16'({6'd0, x_reg} - bnew));
            // gap is ready before the divider may start
            dt_reg <= now_reg - etime_reg[ch_reg];
        end
        if (finish)
        begin
            res_reg.baseline_out <= b_reg;
            res_reg.signal_out <= sig_reg;
            res_reg.frequency <= f_new;
            res_reg.peak <= p_new;
        end
    end
endmodule

@@ rtl/core/lbfd_checker.sv @@
// lbfd_port_checker: port-level assertions for the beacon detector top level
// depends on light_beacon_frequency_detector_core
module lbfd_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [60:0] out_data
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("took two words");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("output dropped");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open with word pending");
    // no frequency means no peak
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data[44:32] == 13'd0) |-> out_data[60:45] == 16'd0)
        else $error("peak check");
endmodule

bind light_beacon_frequency_detector_core lbfd_port_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
    .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);
